FILE: rtl/tsde_pkg.sv
`default_nettype none
package tsde_pkg;

  localparam int TILE_COUNT_DEF = 64;

  // configuration register indexes
  localparam logic REG_SCALE     = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [15:0] SCALE_RST     = 16'd256;
  localparam logic [14:0] THRESHOLD_RST = 15'd0;

  typedef logic signed [15:0] comp16_t;
  typedef logic signed [20:0] comp21_t;

  // carried alongside the tangent normalisation
  typedef struct packed {
    logic [47:0]        b;
    logic [47:0]        n;
    logic [47:0]        d;
    logic signed [19:0] knb;
    logic [21:0]        u;
    logic [21:0]        v;
  } gsa_t;

  // carried alongside the bitangent normalisation
  typedef struct packed {
    logic [47:0] th;
    logic [47:0] n;
    logic [47:0] d;
    logic [21:0] u;
    logic [21:0] v;
  } gsb_t;

  typedef struct packed {
    logic        displaced;
    logic [5:0]  tile;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
    logic [21:0] tex_v;
    logic [21:0] tex_u;
  } res_t;

  function automatic comp16_t lane16(input logic [47:0] v, input int i);
    return comp16_t'(v[16*i +: 16]);
  endfunction

  // round to nearest, halves away from zero, then shift right by s
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] x,
                                                input int unsigned s);
    logic [63:0] half;
    logic [63:0] mag;
    half = 64'd1 << (s - 1);
    mag  = x[63] ? 64'(-x) : 64'(x);
    mag  = (mag + half) >> s;
    return x[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [15:0] colour(input logic signed [50:0] p);
    logic signed [63:0] c;
    c = rnd_sh(64'(p), 18) + 64'sd32768;
    if (c < 64'sd0) begin
      return 16'd0;
    end else if (c > 64'sd65535) begin
      return 16'hFFFF;
    end
    return 16'(c);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tangent_space_displacement_encode.sv
`default_nettype none
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tangent, bitangent, normal, displacement, uv_u, uv_v
// m_*       out  m_tvalid/m_tready  tex_u, tex_v, red, green, blue, tile, displaced
// wr_*      in   wr_en              wr_index selects scale or threshold
//
// One vertex per cycle sustained while s_tready stays high.
// The two normalisations set the depth: a 15-stage square root and an 8-stage
// divider each, two bits per stage.
// rst is synchronous and clears valid bits and the output stage; it returns the registers to their reset values.
// All stages advance together; a two-entry output stage absorbs a stall, so
// s_tready drops only once a result is parked behind an untaken one.
module tangent_space_displacement_encode import tsde_pkg::*; #(
  parameter int TILE_COUNT = TILE_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tangent_vec, bitangent_vec, normal_vec, displacement, uv_u, uv_v, zero pad
  input  logic [239:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tex_u, tex_v, red, green, blue, tile, displaced, zero pad
  output logic [103:0] m_tdata,
  input  logic         wr_en,
  input  logic         wr_index,
  input  logic [15:0]  wr_data
);

  logic [15:0] scale;
  logic [14:0] threshold;
  logic        en;

  logic [4:0]  vld;
  logic [47:0] t0, b0, n0, d0;
  logic [21:0] u0, w0;

  logic signed [31:0] pnt1 [3];
  logic signed [31:0] pnb1 [3];
  logic [47:0] t1, b1, n1, d1;
  logic [21:0] u1, w1;

  logic signed [19:0] knt2, knb2;
  logic [47:0] t2, b2, n2, d2;
  logic [21:0] u2, w2;

  logic signed [35:0] pn3 [3];
  logic signed [19:0] knb3;
  logic [47:0] t3, b3, n3, d3;
  logic [21:0] u3, w3;

  comp21_t tp4 [3];
  gsa_t    gsa4;

  logic    v5;
  comp16_t th5 [3];
  gsa_t    gsa5;

  logic [3:0] vb;
  logic signed [35:0] pnb6 [3];
  logic signed [31:0] ptb6 [3];
  logic [47:0] th6, b6, n6, d6;
  logic [21:0] u6, w6;

  logic signed [18:0] kt7;
  comp21_t part7 [3];
  logic [47:0] th7, n7, d7;
  logic [21:0] u7, w7;

  logic signed [34:0] ptk8 [3];
  comp21_t part8 [3];
  logic [47:0] th8, n8, d8;
  logic [21:0] u8, w8;

  comp21_t bp9 [3];
  gsb_t    gsb9;

  logic    v10;
  comp16_t bh10 [3];
  gsb_t    gsb10;

  logic v11;
  res_t res11;

  logic out_vld, skid_vld;
  res_t out_res, skid_res;

  logic signed [33:0] snt, snb, stb;

  assign en       = !skid_vld;
  assign s_tready = en;
  assign m_tvalid = out_vld;
  assign m_tdata  = {5'd0, out_res};

  assign snt = 34'(pnt1[0]) + 34'(pnt1[1]) + 34'(pnt1[2]);
  assign snb = 34'(pnb1[0]) + 34'(pnb1[1]) + 34'(pnb1[2]);
  assign stb = 34'(ptb6[0]) + 34'(ptb6[1]) + 34'(ptb6[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_RST;
      threshold <= THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCALE:     scale     <= wr_data;
        REG_THRESHOLD: threshold <= wr_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      vb  <= '0;
    end else if (en) begin
      vld <= {vld[3:0], s_tvalid};
      vb  <= {vb[2:0], v5};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= s_tdata[47:0];
      b0 <= s_tdata[95:48];
      n0 <= s_tdata[143:96];
      d0 <= s_tdata[191:144];
      u0 <= s_tdata[213:192];
      w0 <= s_tdata[235:214];

      for (int i = 0; i < 3; i++) begin
        pnt1[i] <= 32'(lane16(n0, i) * lane16(t0, i));
        pnb1[i] <= 32'(lane16(n0, i) * lane16(b0, i));
      end
      {t1, b1, n1, d1, u1, w1} <= {t0, b0, n0, d0, u0, w0};

      knt2 <= 20'(rnd_sh(64'(snt), 14));
      knb2 <= 20'(rnd_sh(64'(snb), 14));
      {t2, b2, n2, d2, u2, w2} <= {t1, b1, n1, d1, u1, w1};

      for (int i = 0; i < 3; i++) begin
        pn3[i] <= 36'(lane16(n2, i) * knt2);
      end
      knb3 <= knb2;
      {t3, b3, n3, d3, u3, w3} <= {t2, b2, n2, d2, u2, w2};

      for (int i = 0; i < 3; i++) begin
        tp4[i] <= 21'(lane16(t3, i)) - 21'(rnd_sh(64'(pn3[i]), 14));
      end
      gsa4.b   <= b3;
      gsa4.n   <= n3;
      gsa4.d   <= d3;
      gsa4.knb <= knb3;
      gsa4.u   <= u3;
      gsa4.v   <= w3;

      for (int i = 0; i < 3; i++) begin
        pnb6[i] <= 36'(lane16(gsa5.n, i) * gsa5.knb);
        ptb6[i] <= 32'(th5[i] * lane16(gsa5.b, i));
      end
      th6 <= {th5[2], th5[1], th5[0]};
      {b6, n6, d6, u6, w6} <= {gsa5.b, gsa5.n, gsa5.d, gsa5.u, gsa5.v};

      kt7 <= 19'(rnd_sh(64'(stb), 14));
      for (int i = 0; i < 3; i++) begin
        part7[i] <= 21'(lane16(b6, i)) - 21'(rnd_sh(64'(pnb6[i]), 14));
      end
      {th7, n7, d7, u7, w7} <= {th6, n6, d6, u6, w6};

      for (int i = 0; i < 3; i++) begin
        ptk8[i] <= 35'(lane16(th7, i) * kt7);
      end
      part8 <= part7;
      {th8, n8, d8, u8, w8} <= {th7, n7, d7, u7, w7};

      for (int i = 0; i < 3; i++) begin
        bp9[i] <= part8[i] - 21'(rnd_sh(64'(ptk8[i]), 14));
      end
      gsb9.th <= th8;
      gsb9.n  <= n8;
      gsb9.d  <= d8;
      gsb9.u  <= u8;
      gsb9.v  <= w8;
    end
  end

  tsde_norm #(.PW($bits(gsa_t))) u_norm_t (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (vld[4]),
    .in_vec  (tp4),
    .in_pt   (gsa4),
    .out_vld (v5),
    .out_vec (th5),
    .out_pt  (gsa5)
  );

  tsde_norm #(.PW($bits(gsb_t))) u_norm_b (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (vb[3]),
    .in_vec  (bp9),
    .in_pt   (gsb9),
    .out_vld (v10),
    .out_vec (bh10),
    .out_pt  (gsb10)
  );

  tsde_proj #(.TILE_COUNT(TILE_COUNT)) u_proj (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (v10),
    .in_bh     (bh10),
    .in_pt     (gsb10),
    .scale     (scale),
    .threshold (threshold),
    .out_vld   (v11),
    .out_res   (res11)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || m_tready) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld <= v11 && en;
      end
    end else if (v11 && en) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || m_tready) begin
      out_res <= skid_vld ? skid_res : res11;
    end
    if (!skid_vld) begin
      skid_res <= res11;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tsde_norm.sv
`default_nettype none
module tsde_norm import tsde_pkg::*; #(
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  comp21_t       in_vec [3],
  input  logic [PW-1:0] in_pt,
  output logic          out_vld,
  output comp16_t       out_vec [3],
  output logic [PW-1:0] out_pt
);

  localparam int RADW  = 60;
  localparam int ROOTW = 30;
  localparam int REMW  = 32;
  localparam int SQ_ST = ROOTW / 2;
  localparam int NUMW  = 44;
  localparam int QW    = 16;
  localparam int DREMW = 30;
  localparam int DV_ST = QW / 2;
  localparam int SBW   = PW + 4 + 60;
  localparam int DSBW  = PW + 4;

  // squares and magnitudes
  logic          s1_vld;
  logic [41:0]   s1_sq  [3];
  logic [19:0]   s1_mag [3];
  logic [2:0]    s1_neg;
  logic [PW-1:0] s1_pt;

  // square root, two result bits a stage
  logic [SQ_ST:0]   q_vld;
  logic [RADW-1:0]  q_rad  [SQ_ST+1];
  logic [REMW-1:0]  q_rem  [SQ_ST+1];
  logic [ROOTW-1:0] q_root [SQ_ST+1];
  logic [SBW-1:0]   q_sb   [SQ_ST+1];
  logic [RADW-1:0]  rad_n  [SQ_ST];
  logic [REMW-1:0]  rem_n  [SQ_ST];
  logic [ROOTW-1:0] root_n [SQ_ST];

  // long division, two quotient bits a stage, three lanes
  logic [DV_ST:0]    d_vld;
  logic [ROOTW-1:0]  d_len [DV_ST+1];
  logic [DSBW-1:0]   d_sb  [DV_ST+1];
  logic [DREMW-1:0]  d_rem [DV_ST+1][3];
  logic [QW-1:0]     d_low [DV_ST+1][3];
  logic [QW-1:0]     d_q   [DV_ST+1][3];
  logic [DREMW-1:0]  drem_n [DV_ST][3];
  logic [QW-1:0]     dlow_n [DV_ST][3];
  logic [QW-1:0]     dq_n   [DV_ST][3];

  logic [39:0]   len2;
  logic [NUMW-1:0] num [3];

  assign len2 = 40'(s1_sq[0]) + 40'(s1_sq[1]) + 40'(s1_sq[2]);

  always_comb begin
    logic [REMW+1:0]  tmp;
    logic [REMW+1:0]  trial;
    logic [RADW-1:0]  rd;
    logic [REMW-1:0]  rm;
    logic [ROOTW-1:0] rt;
    for (int k = 0; k < SQ_ST; k++) begin
      rd = q_rad[k];
      rm = q_rem[k];
      rt = q_root[k];
      for (int j = 0; j < 2; j++) begin
        tmp   = {rm, rd[RADW-1 -: 2]};
        trial = (REMW+2)'({rt, 2'b01});
        rd    = rd << 2;
        if (tmp >= trial) begin
          rm = REMW'(tmp - trial);
          rt = {rt[ROOTW-2:0], 1'b1};
        end else begin
          rm = REMW'(tmp);
          rt = {rt[ROOTW-2:0], 1'b0};
        end
      end
      rad_n[k]  = rd;
      rem_n[k]  = rm;
      root_n[k] = rt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUMW'({q_sb[SQ_ST][20*i +: 20], 24'd0}) + NUMW'(q_root[SQ_ST] >> 1);
    end
  end

  always_comb begin
    logic [DREMW:0]   tmp;
    logic [DREMW-1:0] rm;
    logic [QW-1:0]    lo;
    logic [QW-1:0]    qq;
    for (int k = 0; k < DV_ST; k++) begin
      for (int i = 0; i < 3; i++) begin
        rm = d_rem[k][i];
        lo = d_low[k][i];
        qq = d_q[k][i];
        for (int j = 0; j < 2; j++) begin
          tmp = {rm, lo[QW-1]};
          lo  = lo << 1;
          if (tmp >= (DREMW+1)'(d_len[k])) begin
            rm = DREMW'(tmp - (DREMW+1)'(d_len[k]));
            qq = {qq[QW-2:0], 1'b1};
          end else begin
            rm = DREMW'(tmp);
            qq = {qq[QW-2:0], 1'b0};
          end
        end
        drem_n[k][i] = rm;
        dlow_n[k][i] = lo;
        dq_n[k][i]   = qq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      q_vld   <= '0;
      d_vld   <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= in_vld;
      q_vld   <= {q_vld[SQ_ST-1:0], s1_vld};
      d_vld   <= {d_vld[DV_ST-1:0], q_vld[SQ_ST]};
      out_vld <= d_vld[DV_ST];
    end
  end

  always_ff @(posedge clk) begin
    logic [QW-1:0] qc;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_sq[i]  <= 42'(in_vec[i] * in_vec[i]);
        s1_mag[i] <= in_vec[i][20] ? 20'(-in_vec[i]) : 20'(in_vec[i]);
        s1_neg[i] <= in_vec[i][20];
      end
      s1_pt <= in_pt;

      q_rad[0]  <= {len2, 20'd0};
      q_rem[0]  <= '0;
      q_root[0] <= '0;
      q_sb[0]   <= {s1_pt, s1_neg, (len2 == 40'd0), s1_mag[2], s1_mag[1], s1_mag[0]};
      for (int k = 0; k < SQ_ST; k++) begin
        q_rad[k+1]  <= rad_n[k];
        q_rem[k+1]  <= rem_n[k];
        q_root[k+1] <= root_n[k];
        q_sb[k+1]   <= q_sb[k];
      end

      d_len[0] <= q_root[SQ_ST];
      d_sb[0]  <= q_sb[SQ_ST][SBW-1:60];
      for (int i = 0; i < 3; i++) begin
        d_rem[0][i] <= DREMW'(num[i][NUMW-1:QW]);
        d_low[0][i] <= num[i][QW-1:0];
        d_q[0][i]   <= '0;
      end
      for (int k = 0; k < DV_ST; k++) begin
        d_len[k+1] <= d_len[k];
        d_sb[k+1]  <= d_sb[k];
        for (int i = 0; i < 3; i++) begin
          d_rem[k+1][i] <= drem_n[k][i];
          d_low[k+1][i] <= dlow_n[k][i];
          d_q[k+1][i]   <= dq_n[k][i];
        end
      end

      // zero-length vector comes out as zero; quotient clamps at one
      for (int i = 0; i < 3; i++) begin
        qc = (d_q[DV_ST][i] > QW'(16384)) ? QW'(16384) : d_q[DV_ST][i];
        if (d_sb[DV_ST][0]) begin
          out_vec[i] <= '0;
        end else if (d_sb[DV_ST][1+i]) begin
          out_vec[i] <= -comp16_t'(qc);
        end else begin
          out_vec[i] <= comp16_t'(qc);
        end
      end
      out_pt <= d_sb[DV_ST][DSBW-1:4];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tsde_proj.sv
`default_nettype none
module tsde_proj import tsde_pkg::*; #(
  parameter int TILE_COUNT = TILE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  comp16_t     in_bh [3],
  input  gsb_t        in_pt,
  input  logic [15:0] scale,
  input  logic [14:0] threshold,
  output logic        out_vld,
  output res_t        out_res
);

  localparam logic [8:0] TILE_MAX = 9'(TILE_COUNT - 1);

  logic [4:0] vld;

  // cross and dot products
  logic signed [31:0] cp1 [6];
  logic signed [31:0] pdt1 [3];
  logic signed [31:0] pdb1 [3];
  logic signed [31:0] pdn1 [3];
  comp16_t            bh1 [3];
  logic [43:0]        uv1;

  logic signed [32:0] cr2 [3];
  logic signed [33:0] px2, py2, pz2;
  comp16_t            bh2 [3];
  logic [43:0]        uv2;

  logic signed [48:0] pc3 [3];
  logic signed [33:0] px3, py3, pz3;
  logic [43:0]        uv3;

  logic signed [33:0] px4, py4, pz4;
  logic [43:0]        uv4;

  logic signed [50:0] cx5, cy5, cz5;
  logic [33:0]        mx5;
  logic [5:0]         tile5;
  logic [43:0]        uv5;

  logic signed [50:0] dcb;
  logic signed [16:0] ss;
  logic [33:0]        ax, ay, az, mxy;
  logic [8:0]         tile_i;

  assign dcb = 51'(pc3[0]) + 51'(pc3[1]) + 51'(pc3[2]);
  assign ss  = signed'({1'b0, scale});
  assign ax  = px4[33] ? 34'(-px4) : 34'(px4);
  assign ay  = py4[33] ? 34'(-py4) : 34'(py4);
  assign az  = pz4[33] ? 34'(-pz4) : 34'(pz4);
  assign mxy = (ax > ay) ? ax : ay;
  assign tile_i = {3'd0, uv4[21:16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[3:0], in_vld};
      out_vld <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp1[0] <= 32'(lane16(in_pt.n, 1) * lane16(in_pt.th, 2));
      cp1[1] <= 32'(lane16(in_pt.n, 2) * lane16(in_pt.th, 1));
      cp1[2] <= 32'(lane16(in_pt.n, 2) * lane16(in_pt.th, 0));
      cp1[3] <= 32'(lane16(in_pt.n, 0) * lane16(in_pt.th, 2));
      cp1[4] <= 32'(lane16(in_pt.n, 0) * lane16(in_pt.th, 1));
      cp1[5] <= 32'(lane16(in_pt.n, 1) * lane16(in_pt.th, 0));
      for (int i = 0; i < 3; i++) begin
        pdt1[i] <= 32'(lane16(in_pt.th, i) * lane16(in_pt.d, i));
        pdb1[i] <= 32'(in_bh[i] * lane16(in_pt.d, i));
        pdn1[i] <= 32'(lane16(in_pt.n, i) * lane16(in_pt.d, i));
        bh1[i]  <= in_bh[i];
      end
      uv1 <= {in_pt.v, in_pt.u};

      cr2[0] <= 33'(cp1[0]) - 33'(cp1[1]);
      cr2[1] <= 33'(cp1[2]) - 33'(cp1[3]);
      cr2[2] <= 33'(cp1[4]) - 33'(cp1[5]);
      px2 <= 34'(pdt1[0]) + 34'(pdt1[1]) + 34'(pdt1[2]);
      py2 <= 34'(pdb1[0]) + 34'(pdb1[1]) + 34'(pdb1[2]);
      pz2 <= 34'(pdn1[0]) + 34'(pdn1[1]) + 34'(pdn1[2]);
      bh2 <= bh1;
      uv2 <= uv1;

      for (int i = 0; i < 3; i++) begin
        pc3[i] <= 49'(cr2[i] * bh2[i]);
      end
      px3 <= px2;
      py3 <= py2;
      pz3 <= pz2;
      uv3 <= uv2;

      // left-handed frame: tangent flips, so does its projection
      px4 <= dcb[50] ? -px3 : px3;
      py4 <= py3;
      pz4 <= pz3;
      uv4 <= uv3;

      cx5   <= 51'(px4 * ss);
      cy5   <= 51'(py4 * ss);
      cz5   <= 51'(pz4 * ss);
      mx5   <= (az > mxy) ? az : mxy;
      tile5 <= 6'((tile_i > TILE_MAX) ? TILE_MAX : tile_i);
      uv5   <= uv4;

      out_res.tex_u     <= uv5[21:0];
      out_res.tex_v     <= uv5[43:22];
      out_res.red       <= colour(cx5);
      out_res.green     <= colour(cz5);
      out_res.blue      <= colour(cy5);
      out_res.tile      <= tile5;
      out_res.displaced <= (mx5 > 34'({threshold, 14'd0}));
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
  import tsde_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // tangent_vec, bitangent_vec, normal_vec, displacement, uv_u, uv_v, zero pad
  logic [239:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // tex_u, tex_v, red, green, blue, tile, displaced, zero pad
  logic [103:0] m_tdata;
  logic         wr_en = 1'b0;
  logic         wr_index = REG_SCALE;
  logic [15:0]  wr_data = '0;

  tangent_space_displacement_encode uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int TILE_MAX = 63;

  logic [15:0] gain = SCALE_RST;
  logic [14:0] flag_level = THRESHOLD_RST;
  res_t        pending_px[$];
  int          errors = 0;
  bit          bursts_on = 1'b1;
  bit          in_xfer = 1'b0;
  bit          out_xfer = 1'b0;
  int          quiet_cycles = 0;
  int          stall_left = 0;

  typedef struct {
    logic [239:0] data;
    bit           typed;
    res_t         want;
  } vertex_row_t;

  function automatic logic [47:0] vec(input int x, input int y, input int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic logic [239:0] pack_vertex(input logic [47:0] t, input logic [47:0] b,
                                               input logic [47:0] n, input logic [47:0] d,
                                               input logic [21:0] u, input logic [21:0] v);
    return {4'b0, v, u, d, n, b, t};
  endfunction

  function automatic longint lane(input logic [47:0] p, input int i);
    return longint'($signed(p[16*i +: 16]));
  endfunction

  function automatic longint round_shift(input longint x, input int s);
    longint unsigned half;
    longint unsigned mag;
    half = 64'd1 << (s - 1);
    mag  = (x < 0) ? longint'(-x) : x;
    mag  = (mag + half) >> s;
    return (x < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(input longint v[3], output longint u[3]);
    longint unsigned len2;
    longint unsigned len;
    longint unsigned mag;
    longint unsigned q;
    len2 = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    if (len2 == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return;
    end
    len = int_sqrt(len2 << 20);
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? -v[i] : v[i];
      q = ((mag << 24) + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic logic [15:0] to_colour(input longint proj);
    longint c;
    c = round_shift(proj * longint'(gain), 18) + 32768;
    if (c < 0) c = 0;
    if (c > 65535) c = 65535;
    return c[15:0];
  endfunction

  function automatic res_t encode_vertex(input logic [239:0] din);
    longint t[3], b[3], n[3], d[3], tp[3], bp[3], th[3], bh[3], cr[3];
    longint kn, kt, px, py, pz, mx;
    longint unsigned tl;
    res_t r;
    for (int i = 0; i < 3; i++) begin
      t[i] = lane(din[47:0], i);
      b[i] = lane(din[95:48], i);
      n[i] = lane(din[143:96], i);
      d[i] = lane(din[191:144], i);
    end
    kn = round_shift(n[0]*t[0] + n[1]*t[1] + n[2]*t[2], 14);
    for (int i = 0; i < 3; i++) tp[i] = t[i] - round_shift(n[i]*kn, 14);
    unit_vec(tp, th);
    kn = round_shift(n[0]*b[0] + n[1]*b[1] + n[2]*b[2], 14);
    kt = round_shift(th[0]*b[0] + th[1]*b[1] + th[2]*b[2], 14);
    for (int i = 0; i < 3; i++)
      bp[i] = b[i] - round_shift(n[i]*kn, 14) - round_shift(th[i]*kt, 14);
    unit_vec(bp, bh);
    cr[0] = n[1]*th[2] - n[2]*th[1];
    cr[1] = n[2]*th[0] - n[0]*th[2];
    cr[2] = n[0]*th[1] - n[1]*th[0];
    // left-handed frame: tangent flips
    if (cr[0]*bh[0] + cr[1]*bh[1] + cr[2]*bh[2] < 0)
      for (int i = 0; i < 3; i++) th[i] = -th[i];
    px = th[0]*d[0] + th[1]*d[1] + th[2]*d[2];
    py = bh[0]*d[0] + bh[1]*d[1] + bh[2]*d[2];
    pz = n[0]*d[0] + n[1]*d[1] + n[2]*d[2];
    mx = (px < 0) ? -px : px;
    if (((py < 0) ? -py : py) > mx) mx = (py < 0) ? -py : py;
    if (((pz < 0) ? -pz : pz) > mx) mx = (pz < 0) ? -pz : pz;
    tl = din[213:208];
    if (tl > TILE_MAX) tl = TILE_MAX;
    r.tex_u     = din[213:192];
    r.tex_v     = din[235:214];
    r.red       = to_colour(px);
    r.green     = to_colour(pz);
    r.blue      = to_colour(py);
    r.tile      = tl[5:0];
    r.displaced = (mx > (longint'(flag_level) << 14));
    return r;
  endfunction

  function automatic int rand_comp(input int spread);
    return int'($urandom_range(0, 2*spread)) - spread;
  endfunction

  function automatic logic [239:0] random_vertex();
    logic [239:0] v;
    logic [47:0]  t, n;
    int kind;
    kind = int'($urandom_range(0, 9));
    v = 240'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom});
    v[239:236] = 4'b0;
    if (kind < 2) return v;
    n = vec(rand_comp(16384), rand_comp(16384), rand_comp(16384));
    t = (kind == 2) ? n : (kind == 3) ? 48'd0 :
        vec(rand_comp(32767), rand_comp(32767), rand_comp(32767));
    return pack_vertex(t, vec(rand_comp(32767), rand_comp(32767), rand_comp(32767)), n,
                       vec(rand_comp(4096), rand_comp(4096), rand_comp(4096)),
                       v[213:192], v[235:214]);
  endfunction

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_SCALE) gain = val;
    else flag_level = val[14:0];
  endtask

  task automatic send_vertex(input logic [239:0] din, input bit typed, input res_t want);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= din;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    pending_px.insert(pending_px.size(), typed ? want : encode_vertex(din));
  endtask

  // called at the edge of the last transfer, so valid drops at once
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch expected %0h actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // transfers are sampled mid-cycle, where both sides are settled
  always @(negedge clk) begin
    res_t got, want;
    in_xfer <= !rst && s_tvalid && s_tready;
    out_xfer <= !rst && m_tvalid && m_tready;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[98:0]);
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result %0h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_px.pop_front();
        check_field("tex_u", want.tex_u, got.tex_u);
        check_field("tex_v", want.tex_v, got.tex_v);
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("tile", want.tile, got.tile);
        check_field("displaced", want.displaced, got.displaced);
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= int'($urandom_range(0, 11));
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid || pending_px.size() != 0) && !in_xfer && !out_xfer)
      quiet_cycles <= quiet_cycles + 1;
    else
      quiet_cycles <= 0;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL tangent_space_displacement_encode");
      $finish;
    end
  end

  initial begin
    vertex_row_t rows[$];
    vertex_row_t row;
    logic [15:0] gains[6];
    logic [14:0] levels[6];
    gains  = '{16'd0, 16'hFFFF, 16'd256, 16'hFFFF, 16'd0, 16'd0};
    levels = '{15'd0, 15'h7FFF, 15'd4096, 15'd0, 15'd0, 15'd0};

    // typed rows assume the reset register values
    row.typed = 1'b1;
    row.data = '0;
    row.want = '{displaced: 1'b0, tile: 6'd0, blue: 16'd32768, green: 16'd32768,
                 red: 16'd32768, tex_v: 22'd0, tex_u: 22'd0};
    rows.insert(rows.size(), row);
    row.data = pack_vertex(vec(16384, 0, 0), vec(0, 16384, 0), vec(0, 0, 16384),
                           vec(1024, 0, 0), 22'h05_0000, 22'h3F_FFFF);
    row.want = '{displaced: 1'b1, tile: 6'd5, blue: 16'd32768, green: 16'd32768,
                 red: 16'd49152, tex_v: 22'h3F_FFFF, tex_u: 22'h05_0000};
    rows.insert(rows.size(), row);
    row.data = pack_vertex('0, '0, '0, '0, 22'h3F_FFFF, 22'd0);
    row.want = '{displaced: 1'b0, tile: 6'd63, blue: 16'd32768, green: 16'd32768,
                 red: 16'd32768, tex_v: 22'd0, tex_u: 22'h3F_FFFF};
    rows.insert(rows.size(), row);
    row.typed = 1'b0;
    // left-handed frame
    row.data = pack_vertex(vec(16384, 0, 0), vec(0, -16384, 0), vec(0, 0, 16384),
                           vec(1024, 2048, -512), 22'h3E_0000, 22'h12345);
    rows.insert(rows.size(), row);
    row.data = {4'b0, {236{1'b1}}};
    rows.insert(rows.size(), row);
    row.data = pack_vertex({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                           22'h20_0000, 22'h20_0000);
    rows.insert(rows.size(), row);
    row.data = pack_vertex({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                           22'h1F_FFFF, 22'h1F_FFFF);
    rows.insert(rows.size(), row);
    // tangent along the normal degenerates to zero
    row.data = pack_vertex(vec(0, 0, 9000), vec(0, 16384, 0), vec(0, 0, 16384),
                           vec(300, -300, 300), 22'h01_8000, 22'd7);
    rows.insert(rows.size(), row);
    // normal of half length, used as it stands
    row.data = pack_vertex(vec(12000, 300, 0), vec(-200, 15000, 40), vec(0, 0, 8192),
                           vec(-4096, 4096, 2048), 22'h00_FFFF, 22'd1);
    rows.insert(rows.size(), row);
    row.data = pack_vertex('0, vec(5000, 5000, 0), vec(0, 16384, 0),
                           vec(32767, -32768, 1), 22'd0, 22'd0);
    rows.insert(rows.size(), row);
    row.data = pack_vertex(vec(3, -7, 11), vec(-5, 2, 9), vec(11585, 11585, 0),
                           vec(-1, 1, -1), 22'h2A_AAAA, 22'h15_5555);
    rows.insert(rows.size(), row);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (rows[i]) send_vertex(rows[i].data, rows[i].typed, rows[i].want);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p >= 4) begin
        gains[p] = 16'($urandom_range(0, 65535));
        levels[p] = 15'($urandom_range(0, 32767));
      end
      write_reg(REG_SCALE, gains[p]);
      write_reg(REG_THRESHOLD, {1'b0, levels[p]});
      bursts_on = (p != 5);
      for (int k = 0; k < 275; k++) send_vertex(random_vertex(), 1'b0, '0);
      drain();
    end

    if (errors == 0) begin
      $display("PASS tangent_space_displacement_encode");
    end else begin
      $display("FAIL tangent_space_displacement_encode");
    end
    $finish;
  end

endmodule
`default_nettype wire
